// ===== sv/double_ended_queue_defines.svh =====
// Assertion macros for the double-ended queue.
// Included by the top-level module to check its own logic; depends on clk and rst in scope.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH
`ifndef ASSERT_OFF
`define DEQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DEQ_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define DEQ_ASSERT(label, prop, msg)
`define DEQ_ASSERT_NEVER(label, expr, msg)
`endif
`endif

// ===== sv/deq_pkg.sv =====
// Shared constants, types and ring-pointer helpers for the double-ended queue.
// No dependencies.
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int DW    = 32;

  localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
  localparam logic [2:0] REQ_PUSH_REAR  = 3'd1;
  localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
  localparam logic [2:0] REQ_POP_REAR   = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [1:0] ST_OVERFLOW  = 2'd2;

  localparam logic [DW-1:0] EMPTY_VALUE = {1'b1, {(DW-1){1'b0}}};

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic [AW-1:0] raddr0;
    logic [AW-1:0] raddr1;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]    status;
    logic [CW-1:0] count;
  } req_info_t;

  function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] i);
    ring_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] i);
    ring_prev = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

endpackage

// ===== sv/deq_ram.sv =====
// Generic synchronous RAM: one write port, two registered read ports.
// No dependencies.
module deq_ram #(
  parameter int WIDTH   = 32,
  parameter int ENTRIES = 16,
  parameter int ABITS   = $clog2(ENTRIES)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr0,
  input  logic [ABITS-1:0] raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ===== sv/deq_ctrl.sv =====
// Pointer and count control: decodes a request, updates head, tail and count,
// and issues the ring write and the front/rear reads. Depends on deq_pkg.
module deq_ctrl import deq_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          acc,
  input  logic [2:0]    req_type,
  input  logic [DW-1:0] data_value,
  output mem_req_t      mem_req,
  output req_info_t     info
);

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [1:0]    status;
  logic          wr;
  logic [AW-1:0] waddr;
  logic          full, empty;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    status     = ST_OK;
    wr         = 1'b0;
    waddr      = tail;
    unique case (req_type)
      REQ_PUSH_FRONT: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          head_next  = ring_prev(head);
          waddr      = head_next;
          wr         = 1'b1;
          count_next = count + CW'(1);
        end
      end
      REQ_PUSH_REAR: begin
        if (full) begin
          status = ST_OVERFLOW;
        end else begin
          waddr      = tail;
          wr         = 1'b1;
          tail_next  = ring_next(tail);
          count_next = count + CW'(1);
        end
      end
      REQ_POP_FRONT: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          head_next  = ring_next(head);
          count_next = count - CW'(1);
        end
      end
      REQ_POP_REAR: begin
        if (empty) begin
          status = ST_UNDERFLOW;
        end else begin
          tail_next  = ring_prev(tail);
          count_next = count - CW'(1);
        end
      end
      REQ_CLEAR: begin
        head_next  = '0;
        tail_next  = '0;
        count_next = '0;
      end
      default: begin
      end
    endcase
  end

  assign mem_req.we     = acc & wr;
  assign mem_req.waddr  = waddr;
  assign mem_req.wdata  = data_value;
  assign mem_req.raddr0 = head_next;
  assign mem_req.raddr1 = ring_prev(tail_next);
  assign info.status    = status;
  assign info.count     = count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (acc) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

endmodule

// ===== sv/double_ended_queue.sv =====
// Double-ended queue top level: ring memory, pointer control and result register.
// An accepted request reads the ring into the RAM read registers, then loads the result
// register that drives m_tvalid. No new request is taken while that ring read is in
// flight or while a result waits on m_tready. Reset (rst, synchronous) empties the queue;
// ring contents are not cleared. Depends on deq_pkg, deq_ctrl, deq_ram.
`include "double_ended_queue_defines.svh"
module double_ended_queue import deq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // [31:0] data_value
  input  logic [2:0]  s_tuser,  // [2:0] req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata   // [1:0] status, [33:2] front_value, [65:34] rear_value,
                                // [70:66] item_count, [71] is_empty
);

  logic          acc;
  mem_req_t      mem_req;
  req_info_t     info;
  logic [DW-1:0] rdata0, rdata1;
  logic          pend;
  req_info_t     pend_info;
  logic          fwd0, fwd1;
  logic [DW-1:0] fwd_data;
  logic [DW-1:0] front_value, rear_value;
  logic          is_empty;

  assign s_tready = !pend && (!m_tvalid || m_tready);
  assign acc      = s_tvalid && s_tready;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .req_type   (s_tuser),
    .data_value (s_tdata),
    .mem_req    (mem_req),
    .info       (info)
  );

  deq_ram #(
    .WIDTH   (DW),
    .ENTRIES (DEPTH)
  ) u_ram (
    .clk    (clk),
    .we     (mem_req.we),
    .waddr  (mem_req.waddr),
    .wdata  (mem_req.wdata),
    .raddr0 (mem_req.raddr0),
    .raddr1 (mem_req.raddr1),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  // forward a write that lands on an address read in the same cycle
  always_ff @(posedge clk) begin
    pend_info <= info;
    fwd0      <= mem_req.we && (mem_req.waddr == mem_req.raddr0);
    fwd1      <= mem_req.we && (mem_req.waddr == mem_req.raddr1);
    fwd_data  <= mem_req.wdata;
  end

  assign is_empty    = (pend_info.count == '0);
  assign front_value = is_empty ? EMPTY_VALUE : (fwd0 ? fwd_data : rdata0);
  assign rear_value  = is_empty ? EMPTY_VALUE : (fwd1 ? fwd_data : rdata1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      pend <= acc;
      if (pend) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend) begin
      m_tdata <= {is_empty, 5'(pend_info.count), rear_value, front_value, pend_info.status};
    end
  end

  `DEQ_ASSERT(a_acc_pend, acc |=> pend, "accepted request did not reach read stage")
  `DEQ_ASSERT(a_pend_out, pend |=> m_tvalid, "read stage did not load result register")
  `DEQ_ASSERT_NEVER(a_pend_ready, pend && s_tready, "request taken while read in flight")
  `DEQ_ASSERT(a_empty_flag, m_tvalid |-> m_tdata[71] == (m_tdata[70:66] == '0), "bad empty flag")
  `DEQ_ASSERT_NEVER(a_count_max, info.count > CW'(DEPTH), "count above depth")

endmodule

// ===== tb/tb_double_ended_queue.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for double_ended_queue: directed and random push, pop and clear
// requests against an in-bench ring model, with random idling on both stream sides.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
  import deq_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 200;

  typedef struct {
    logic [2:0]  req;
    logic [31:0] value;
    int          gap;
  } deq_request_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] front_value;
    logic [31:0] rear_value;
    logic [4:0]  item_count;
    logic        is_empty;
    int          stamp;
  } deq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] data_value
  logic [2:0]  s_tuser = '0;   // [2:0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;        // [1:0] status, [33:2] front_value, [65:34] rear_value,
                               // [70:66] item_count, [71] is_empty

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #2 clk = ~clk;

  deq_request_t request_plan[$];
  deq_result_t  expected_results[$];

  logic [31:0] model_ring [DEPTH];
  int model_head = 0;
  int model_tail = 0;
  int model_fill = 0;

  int cycle_count   = 0;
  int requests_sent = 0;
  int results_seen  = 0;
  int failures      = 0;
  int hold_at       = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  bit send_calm     = 1'b0;
  int burst_left    = 0;

  int overflow_seen  = 0;
  int underflow_seen = 0;
  int clear_seen     = 0;
  int peak_fill      = 0;

  function automatic deq_result_t apply_request(logic [2:0] req, logic [31:0] val);
    deq_result_t r;
    r.status = ST_OK;
    case (req)
      REQ_PUSH_FRONT: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_head = (model_head + DEPTH - 1) % DEPTH;
          model_ring[model_head] = val;
          model_fill++;
        end
      end
      REQ_PUSH_REAR: begin
        if (model_fill >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else begin
          model_ring[model_tail] = val;
          model_tail = (model_tail + 1) % DEPTH;
          model_fill++;
        end
      end
      REQ_POP_FRONT: begin
        if (model_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          model_head = (model_head + 1) % DEPTH;
          model_fill--;
        end
      end
      REQ_POP_REAR: begin
        if (model_fill == 0) begin
          r.status = ST_UNDERFLOW;
        end else begin
          model_tail = (model_tail + DEPTH - 1) % DEPTH;
          model_fill--;
        end
      end
      REQ_CLEAR: begin
        model_head = 0;
        model_tail = 0;
        model_fill = 0;
        clear_seen++;
      end
      default: ;
    endcase
    if (model_fill == 0) begin
      r.front_value = EMPTY_VALUE;
      r.rear_value  = EMPTY_VALUE;
    end else begin
      r.front_value = model_ring[model_head];
      r.rear_value  = model_ring[(model_tail + DEPTH - 1) % DEPTH];
    end
    r.item_count = 5'(model_fill);
    r.is_empty   = (model_fill == 0);
    r.stamp      = 0;
    if (r.status == ST_OVERFLOW) overflow_seen++;
    if (r.status == ST_UNDERFLOW) underflow_seen++;
    if (model_fill > peak_fill) peak_fill = model_fill;
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic void plan(logic [2:0] req, logic [31:0] val);
    deq_request_t item;
    item.req   = req;
    item.value = val;
    item.gap   = (send_calm || burst_left > 0) ? 0 : $urandom_range(0, 19);
    if (burst_left > 0) burst_left--;
    request_plan.push_back(item);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("double_ended_queue verification failed");
      $finish;
    end
  end

  // Driver: offer planned requests, predict on each accepted one.
  deq_request_t staged;
  bit           have_item = 1'b0;
  bit           offering  = 1'b0;
  int           gap_left  = 0;

  always @(posedge clk) begin
    deq_result_t predicted;
    if (rst) begin
      s_tvalid  <= 1'b0;
      s_tdata   <= '0;
      s_tuser   <= '0;
      offering  = 1'b0;
      have_item = 1'b0;
      gap_left  = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predicted = apply_request(s_tuser, s_tdata);
        predicted.stamp = cycle_count;
        expected_results.push_back(predicted);
        requests_sent <= requests_sent + 1;
        offering  = 1'b0;
        have_item = 1'b0;
      end
      if (!have_item && request_plan.size() > 0) begin
        staged    = request_plan.pop_front();
        have_item = 1'b1;
        gap_left  = staged.gap;
      end
      if (have_item && !offering) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          offering = 1'b1;
          s_tuser  <= staged.req;
          s_tdata  <= staged.value;
        end
      end
      s_tvalid <= offering;
    end
  end

  // Long receiver hold-off so the block backs up and stalls its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && requests_sent >= hold_at) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Monitor: accept results with random stalls and compare with predictions.
  int sink_wait = 0;
  bit sink_calm = 1'b0;

  always @(posedge clk) begin
    deq_result_t want;
    if (rst) begin
      m_tready  <= 1'b0;
      sink_wait = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0 || expected_results[0].stamp == cycle_count) begin
          $error("result with no request outstanding: %h", m_tdata);
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (m_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
            failures++;
          end
          if (m_tdata[33:2] !== want.front_value) begin
            $error("front_value: expected %h, got %h", want.front_value, m_tdata[33:2]);
            failures++;
          end
          if (m_tdata[65:34] !== want.rear_value) begin
            $error("rear_value: expected %h, got %h", want.rear_value, m_tdata[65:34]);
            failures++;
          end
          if (m_tdata[70:66] !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count, m_tdata[70:66]);
            failures++;
          end
          if (m_tdata[71] !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, m_tdata[71]);
            failures++;
          end
        end
        if ($urandom_range(0, 59) == 0) sink_calm = ($urandom_range(0, 2) == 0);
        sink_wait = sink_calm ? 0 : $urandom_range(0, 19);
      end else if (sink_wait > 0) begin
        sink_wait--;
      end
      m_tready <= (sink_wait == 0) && (hold_left == 0);
    end
  end

  initial begin
    int counted;
    int phase;
    int push_pct;
    int planned_total;
    int i;

    // Directed: underflow on empty, extremes, unused codes, fill to overflow, clears.
    plan(REQ_POP_FRONT, 32'h0);
    plan(REQ_POP_REAR, 32'hffff_ffff);
    plan(REQ_PUSH_FRONT, 32'h7fff_ffff);
    plan(REQ_PUSH_REAR, 32'h8000_0000);
    plan(REQ_PUSH_FRONT, 32'h0000_0000);
    plan(REQ_PUSH_REAR, 32'hffff_ffff);
    plan(3'd5, 32'h1234_5678);
    plan(3'd6, 32'h0);
    plan(3'd7, 32'hffff_ffff);
    plan(REQ_POP_FRONT, 32'h0);
    plan(REQ_POP_REAR, 32'h0);
    for (i = 0; i < 14; i++) plan(i[0] ? REQ_PUSH_FRONT : REQ_PUSH_REAR, $urandom());
    plan(REQ_PUSH_FRONT, 32'h5555_5555);
    plan(REQ_PUSH_REAR, 32'haaaa_aaaa);
    plan(REQ_CLEAR, 32'h0);
    plan(REQ_CLEAR, 32'hffff_ffff);

    // Random: fill, drain and mixed stretches so the count sweeps the whole range.
    counted  = 0;
    phase    = 0;
    while (counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 39) == 0) begin
        phase     = $urandom_range(0, 2);
        send_calm = ($urandom_range(0, 3) == 0);
      end
      if (counted == 300 && hold_at == 0) begin
        hold_at    = request_plan.size();
        burst_left = 60;
      end
      push_pct = (phase == 0) ? 80 : (phase == 1) ? 20 : 50;
      case ($urandom_range(0, 99)) inside
        [0:1]: begin
          plan(REQ_CLEAR, pick_value());
          counted++;
        end
        [2:4]: plan(3'($urandom_range(5, 7)), pick_value());
        default: begin
          if ($urandom_range(0, 99) < push_pct)
            plan($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_REAR, pick_value());
          else
            plan($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_REAR, pick_value());
          counted++;
        end
      endcase
    end
    planned_total = request_plan.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (requests_sent < planned_total || expected_results.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_results.size() > 0) begin
      $error("%0d results never arrived", expected_results.size());
      failures++;
    end

    $display("Ran %0d requests, %0d results checked, peak fill %0d of %0d.",
             requests_sent, results_seen, peak_fill, DEPTH);
    $display("Saw %0d overflows, %0d underflows, %0d clears and a %0d-cycle output stall.",
             overflow_seen, underflow_seen, clear_seen, HOLD_CYCLES);
    if (failures == 0) begin
      $display("double_ended_queue verification clean");
    end else begin
      $display("double_ended_queue verification failed");
    end
    $finish;
  end

endmodule
